// ----- sv/dvrt_pkg.sv -----
// Shared types and constants of the distance-vector route table unit.
package dvrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W    = 32;
    localparam int DIST_W    = 8;
    localparam int ID_W      = 8;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0] OWN_NET_RESET  = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] OWN_MASK_RESET = 32'hFFFF_FF00;
    localparam logic [DIST_W-1:0] DIST_MAX       = 8'hFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_FORWARD = 2'd0,
        REQ_UPDATE  = 2'd1,
        REQ_LOAD    = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DIRECT   = 3'd0,
        ST_FORWARD  = 3'd1,
        ST_EXPIRED  = 3'd2,
        ST_NOROUTE  = 3'd3,
        ST_REPLACED = 3'd4,
        ST_ADDED    = 3'd5,
        ST_IGNORED  = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_NET  = 1'b0,
        CFG_OWN_MASK = 1'b1
    } t_cfg_reg;

    // What the table engine has to do with a request.
    typedef enum logic [1:0] {
        CMD_FINISHED = 2'd0,
        CMD_LOOKUP   = 2'd1,
        CMD_UPDATE   = 2'd2,
        CMD_LOAD     = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        t_status           status;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [DIST_W-1:0] hops;
        logic [ADDR_W-1:0] nip;
        logic [ID_W-1:0]   nid;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ID_W-1:0]   nid;
        logic [ADDR_W-1:0] nip;
        logic [DIST_W-1:0] hops;
    } t_entry;

    typedef enum logic [1:0] {
        B_IDLE   = 2'd0,
        B_SCAN   = 2'd1,
        B_APPEND = 2'd2,
        B_DONE   = 2'd3
    } t_back_state;

    typedef struct packed {
        t_back_state      state;
        logic [CNT_W-1:0] count;
    } t_back_stat;

endpackage

// ----- sv/dvrt_front.sv -----
// Request front end: configuration registers and classification of incoming beats.
module dvrt_front
    import dvrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // dest_addr, entry_mask, entry_distance, from_ip, from_id, hop_limit
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  logic [REQ_W-1:0]     i_s_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output t_cmd                 o_cmd
);

    logic [ADDR_W-1:0] r_own_net;
    logic [ADDR_W-1:0] r_own_mask;

    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [DIST_W-1:0] adv_dist;
    logic [ADDR_W-1:0] fip;
    logic [ID_W-1:0]   fid;
    logic [DIST_W-1:0] life;

    assign dest     = i_s_tdata[31:0];
    assign mask     = i_s_tdata[63:32];
    assign adv_dist = i_s_tdata[71:64];
    assign fip      = i_s_tdata[103:72];
    assign fid      = i_s_tdata[111:104];
    assign life     = i_s_tdata[119:112];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_net  <= OWN_NET_RESET;
            r_own_mask <= OWN_MASK_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_OWN_NET:  r_own_net  <= i_cfg_data;
                CFG_OWN_MASK: r_own_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready  = i_cmd_ready;
    assign o_cmd_valid = i_s_tvalid;

    always_comb begin
        o_cmd.kind   = CMD_FINISHED;
        o_cmd.status = ST_IGNORED;
        o_cmd.dest   = dest;
        o_cmd.mask   = mask;
        o_cmd.hops   = adv_dist;
        o_cmd.nip    = fip;
        o_cmd.nid    = fid;
        case (t_req'(i_s_tuser))
            REQ_FORWARD: begin
                if (life == '0) begin
                    o_cmd.status = ST_EXPIRED;
                end else if ((dest & r_own_mask) == r_own_net) begin
                    o_cmd.status = ST_DIRECT;
                end else begin
                    o_cmd.kind = CMD_LOOKUP;
                end
            end
            REQ_UPDATE: begin
                // An advertised route costs one more hop through the neighbor.
                o_cmd.hops = (adv_dist == DIST_MAX) ? DIST_MAX : adv_dist + 1'b1;
                if (dest != r_own_net) begin
                    o_cmd.kind = CMD_UPDATE;
                end
            end
            REQ_LOAD: begin
                o_cmd.kind = CMD_LOAD;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/dvrt_queue.sv -----
// Short command queue between the front end and the table engine.
module dvrt_queue
    import dvrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;

    logic push;
    logic pop;

    assign o_push_ready = (r_level != QLVL_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_level != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

// ----- sv/dvrt_back.sv -----
// Table engine: route memory, sequential scan, replace and append, result register.
module dvrt_back
    import dvrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  t_cmd                 i_cmd,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // next_hop_id, next_hop_ip
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // status, table_full
    output logic [M_TUSER_W-1:0] o_m_tuser,
    output t_back_stat           o_stat
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_q;
    logic [IDX_W-1:0] r_q_idx;

    t_back_state r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic r_q_vld, n_q_vld;
    logic r_matched, n_matched;
    logic r_replaced, n_replaced;
    t_status           r_res, n_res;
    logic              r_res_full, n_res_full;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic [ADDR_W-1:0] r_res_ip, n_res_ip;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic              r_out_full, n_out_full;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic [ADDR_W-1:0] r_out_ip, n_out_ip;

    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
        r_q     <= r_mem[rd_addr];
        r_q_idx <= rd_addr;
    end

    assign wr_entry.dest = r_cmd.dest;
    assign wr_entry.mask = r_cmd.mask;
    assign wr_entry.nid  = r_cmd.nid;
    assign wr_entry.nip  = r_cmd.nip;
    assign wr_entry.hops = r_cmd.hops;

    assign issue   = (r_idx < r_count);
    assign rd_addr = r_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_q_vld     <= n_q_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_matched    <= n_matched;
        r_replaced   <= n_replaced;
        r_res        <= n_res;
        r_res_full   <= n_res_full;
        r_res_id     <= n_res_id;
        r_res_ip     <= n_res_ip;
        r_out_status <= n_out_status;
        r_out_full   <= n_out_full;
        r_out_id     <= n_out_id;
        r_out_ip     <= n_out_ip;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_idx        = r_idx;
        n_q_vld      = 1'b0;
        n_matched    = r_matched;
        n_replaced   = r_replaced;
        n_res        = r_res;
        n_res_full   = r_res_full;
        n_res_id     = r_res_id;
        n_res_ip     = r_res_ip;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_full   = r_out_full;
        n_out_id     = r_out_id;
        n_out_ip     = r_out_ip;
        o_cmd_ready  = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_q_idx;

        case (r_state)
            B_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_idx      = '0;
                    n_matched  = 1'b0;
                    n_replaced = 1'b0;
                    n_res      = i_cmd.status;
                    n_res_full = 1'b0;
                    n_res_id   = '0;
                    n_res_ip   = '0;
                    case (i_cmd.kind)
                        CMD_LOOKUP, CMD_UPDATE: n_state = B_SCAN;
                        CMD_LOAD:               n_state = B_APPEND;
                        default:                n_state = B_DONE;
                    endcase
                end
            end
            B_SCAN: begin
                // Reads run one entry ahead of the compare on the registered read data.
                n_q_vld = issue;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_q_vld) begin
                    if (r_cmd.kind == CMD_LOOKUP) begin
                        if ((r_cmd.dest & r_q.mask) == r_q.dest) begin
                            n_res    = ST_FORWARD;
                            n_res_id = r_q.nid;
                            n_res_ip = r_q.nip;
                            n_q_vld  = 1'b0;
                            n_state  = B_DONE;
                        end
                    end else if (r_q.dest == r_cmd.dest) begin
                        n_matched = 1'b1;
                        if (r_q.nip == r_cmd.nip || r_cmd.hops < r_q.hops) begin
                            wr_en      = 1'b1;
                            n_replaced = 1'b1;
                        end
                    end
                end else if (!issue) begin
                    if (r_cmd.kind == CMD_LOOKUP) begin
                        n_res   = ST_NOROUTE;
                        n_state = B_DONE;
                    end else if (r_replaced) begin
                        n_res   = ST_REPLACED;
                        n_state = B_DONE;
                    end else if (r_matched) begin
                        n_res   = ST_IGNORED;
                        n_state = B_DONE;
                    end else begin
                        n_state = B_APPEND;
                    end
                end
            end
            B_APPEND: begin
                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_res      = ST_IGNORED;
                    n_res_full = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[IDX_W-1:0];
                    n_count = r_count + 1'b1;
                    n_res   = ST_ADDED;
                end
                n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res;
                    n_out_full   = r_res_full;
                    n_out_id     = r_res_id;
                    n_out_ip     = r_res_ip;
                    n_state      = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {r_out_ip, r_out_id};
    assign o_m_tuser    = {r_out_full, r_out_status};
    assign o_stat.state = r_state;
    assign o_stat.count = r_count;

endmodule

// ----- sv/distance_vector_route_table_unit.sv -----
// A request that needs no table access passes the queue and the engine's idle and
// done states into the result register. A lookup or update first scans the stored
// routes one entry per cycle over the single read port, a lookup stopping at its
// first match. One request is served at a time; a two-deep queue takes beats.
// Reset (synchronous, active low) empties the table and queue and restores the
// own-network registers to 0.0.0.0 and 255.255.255.0.
module distance_vector_route_table_unit
    import dvrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // dest_addr, entry_mask, entry_distance, from_ip, from_id, hop_limit
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  logic [REQ_W-1:0]     i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // next_hop_id, next_hop_ip
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // status, table_full
    output logic [M_TUSER_W-1:0] o_m_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    logic       front_valid;
    logic       front_ready;
    t_cmd       front_cmd;
    logic       queue_valid;
    logic       queue_ready;
    t_cmd       queue_cmd;
    t_back_stat back_stat;

    dvrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    dvrt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_cmd    (queue_cmd)
    );

    dvrt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_stat      (back_stat)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.count <= CNT_W'(TABLE_DEPTH))
        else $error("route count exceeds table depth");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> back_stat.count >= $past(back_stat.count))
        else $error("route count decreased without reset");

    a_append_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.state == B_APPEND |=> back_stat.state == B_DONE)
        else $error("append did not complete in one cycle");

    a_full_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3] |-> o_m_tuser[2:0] == ST_IGNORED)
        else $error("table full flagged on a result that is not ignored");
`endif

endmodule
